// ===== design/bpc_pkg.sv =====
// Package for the barometric pressure compensation core.
// Widths, constants, register indexes and stage records; no dependencies.
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int RawW        = 20;
  localparam int TempW       = 20;
  localparam int UW          = 21;
  localparam int OutW        = 21;
  localparam int OutFracBits = 4;
  localparam int OutShift    = 16 - OutFracBits;
  localparam int MW          = 58;
  localparam int KW          = 53;
  localparam int DW          = 45;
  localparam int RW          = DW + 1;
  localparam int QW          = 33;
  localparam int DivSteps    = QW;
  localparam int ScaleW      = 18;
  localparam int AW          = MW + ScaleW;
  localparam int HalfW       = MW / 2;
  localparam int PW          = QW;
  localparam int SumW        = 44;

  localparam logic signed [UW-1:0] TempOffset = 21'sd128000;
  localparam logic [ScaleW-1:0]    PScale     = 18'd200000;
  localparam logic [QW-1:0]        PcLim      = 33'h0_FFFF_FFFF;
  localparam logic [OutW-1:0]      OutMax     = {OutW{1'b1}};

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StSat     = 2'd1,
    StDivZero = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RegP1    = 3'd0,
    RegP2    = 3'd1,
    RegP4    = 3'd2,
    RegP5    = 3'd3,
    RegP8    = 3'd4,
    RegP9    = 3'd5,
    RegSmall = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p3;
    logic signed [7:0]  p6;
    logic signed [7:0]  p7;
    logic [7:0]         p10;
  } cal_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          dz;
    logic [AW-1:0] num;
    logic [DW-1:0] den;
  } poly_res_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          dz;
    logic          ovf;
    logic [QW-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic                   valid;
    logic                   dz;
    logic                   sat;
    logic signed [SumW-1:0] r;
  } post_res_t;

endpackage

// ===== design/bpc_if.sv =====
// Request channel interfaces for the compensation core.
// Depends on bpc_pkg for the payload widths.
`timescale 1ns / 1ps
interface bpc_in_if;
  import bpc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [RawW-1:0]         raw_pressure;
  logic signed [TempW-1:0] temp_fine;
  modport source (output valid, raw_pressure, temp_fine, input ready);
  modport sink (input valid, raw_pressure, temp_fine, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] pressure_q4;
  logic [1:0]      status;
  modport source (output valid, pressure_q4, status, input ready);
  modport sink (input valid, pressure_q4, status, output ready);
endinterface

// ===== design/bpc_poly.sv =====
// Front pipeline: temperature terms, divisor and scaled numerator, seven stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_poly import bpc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [RawW-1:0]         raw_pressure_i,
  input  logic signed [TempW-1:0] temp_fine_i,
  input  cal_t                    cal_i,
  output poly_res_t               res_o
);

  logic [7:1] v_q;

  logic signed [UW-1:0]  u1_q;
  logic [RawW-1:0]       raw1_q, raw2_q, raw3_q, raw4_q;
  logic signed [2*UW-1:0] uu2_q;
  logic signed [UW+15:0] up5_2_q, up2_2_q, up5_3_q, up2_3_q;
  logic signed [2*UW+7:0] a3_q, b3_q;
  logic signed [MW-1:0]  n2_4_q, m5_q;
  logic signed [KW-1:0]  k4_q;
  logic [DW-1:0]         d5_q, d6_q, d7_q;
  logic [MW-1:0]         mag;
  logic [HalfW+ScaleW-1:0] lo6_q, hi6_q;
  logic                  neg6_q, neg7_q, dz6_q, dz7_q;
  logic [AW-1:0]         a7_q;
  logic [UW-1:0]         rinv;

  assign mag  = m5_q[MW-1] ? MW'(-m5_q) : MW'(m5_q);
  assign rinv = (UW'(1) << RawW) - UW'(raw4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q    <= UW'(temp_fine_i) - TempOffset;
      raw1_q  <= raw_pressure_i;
      uu2_q   <= u1_q * u1_q;
      up5_2_q <= u1_q * cal_i.p5;
      up2_2_q <= u1_q * cal_i.p2;
      raw2_q  <= raw1_q;
      a3_q    <= uu2_q * cal_i.p6;
      b3_q    <= uu2_q * cal_i.p3;
      up5_3_q <= up5_2_q;
      up2_3_q <= up2_2_q;
      raw3_q  <= raw2_q;
      n2_4_q  <= MW'(a3_q) + (MW'(up5_3_q) <<< 19) + (MW'(cal_i.p4) <<< 37);
      k4_q    <= (KW'(1) <<< 50) + KW'(b3_q) + (KW'(up2_3_q) <<< 15);
      raw4_q  <= raw3_q;
      d5_q    <= DW'(cal_i.p1) * DW'(k4_q[KW-1:24]);
      m5_q    <= $signed({4'd0, rinv, 33'd0}) - n2_4_q;
      neg6_q  <= m5_q[MW-1];
      dz6_q   <= (d5_q == '0);
      d6_q    <= d5_q;
      lo6_q   <= (HalfW+ScaleW)'(mag[HalfW-1:0]) * (HalfW+ScaleW)'(PScale);
      hi6_q   <= (HalfW+ScaleW)'(mag[MW-1:HalfW]) * (HalfW+ScaleW)'(PScale);
      a7_q    <= (AW'(hi6_q) << HalfW) + AW'(lo6_q);
      neg7_q  <= neg6_q;
      dz7_q   <= dz6_q;
      d7_q    <= d6_q;
    end
  end

  assign res_o = '{valid: v_q[7], neg: neg7_q, dz: dz7_q, num: a7_q, den: d7_q};

endmodule

// ===== design/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow precheck.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_div import bpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  poly_res_t req_i,
  output div_res_t  res_o
);

  logic [DivSteps:0] v_q;
  logic [RW-1:0]     rem_q [DivSteps+1];
  logic [QW-1:0]     low_q [DivSteps+1];
  logic [QW-1:0]     quo_q [DivSteps+1];
  logic [DW-1:0]     d_q   [DivSteps+1];
  logic [DivSteps:0] neg_q, dz_q, ovf_q;
  logic [RW-1:0]     trial [DivSteps+1];
  logic [DivSteps:0] ge;

  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int i = 1; i <= DivSteps; i++) begin
      trial[i] = {rem_q[i-1][RW-2:0], low_q[i-1][QW-1]};
      ge[i]    = (trial[i] >= RW'(d_q[i-1]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-1:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(req_i.num[AW-1:QW]);
      low_q[0] <= req_i.num[QW-1:0];
      quo_q[0] <= '0;
      d_q[0]   <= req_i.den;
      neg_q[0] <= req_i.neg;
      dz_q[0]  <= req_i.dz;
      ovf_q[0] <= (DW'(req_i.num[AW-1:QW]) >= req_i.den);
      for (int i = 1; i <= DivSteps; i++) begin
        rem_q[i] <= ge[i] ? trial[i] - RW'(d_q[i-1]) : trial[i];
        low_q[i] <= low_q[i-1] << 1;
        quo_q[i] <= {quo_q[i-1][QW-2:0], ge[i]};
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
        dz_q[i]  <= dz_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  assign res_o = '{valid: v_q[DivSteps], neg: neg_q[DivSteps], dz: dz_q[DivSteps],
                   ovf: ovf_q[DivSteps], quo: quo_q[DivSteps]};

endmodule

// ===== design/bpc_post.sv =====
// Back pipeline: clamps the first estimate and adds the correction terms, six stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_post import bpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  div_res_t  req_i,
  input  cal_t      cal_i,
  output post_res_t res_o
);

  logic [6:1] v_q, dz_q, sat_q;
  logic       sat_in;
  logic [31:0] s_in;

  logic [31:0]           s1_q, s2_q;
  logic signed [PW-1:0]  p1_q, p2_q, p3_q, p4_q;
  logic [63:0]           sq2_q;
  logic signed [PW+15:0] p8p2_q;
  logic signed [60:0]    t1p3_q;
  logic [59:0]           b3_q, c4_q;
  logic signed [33:0]    t2_3_q;
  logic signed [37:0]    t1_4_q;
  logic signed [SumW-1:0] sum4_q, sum5_q, r6_q;
  logic signed [39:0]    t3_5_q;
  logic signed [60:0]    t1w;
  logic signed [PW+15:0] t2w;

  assign sat_in = req_i.ovf || (req_i.quo > PcLim);
  assign s_in   = sat_in ? PcLim[31:0] : req_i.quo[31:0];
  assign t1w    = t1p3_q + (t1p3_q[60] ? 61'sd8388607 : 61'sd0);
  assign t2w    = p8p2_q + (p8p2_q[PW+15] ? (PW+16)'(32767) : (PW+16)'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:1], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dz_q   <= {dz_q[5:1], req_i.dz};
      sat_q  <= {sat_q[5:1], sat_in};
      s1_q   <= s_in;
      p1_q   <= req_i.neg ? -$signed({1'b0, s_in}) : $signed({1'b0, s_in});
      sq2_q  <= 64'(s1_q) * 64'(s1_q);
      p8p2_q <= p1_q * cal_i.p8;
      s2_q   <= s1_q;
      p2_q   <= p1_q;
      t1p3_q <= cal_i.p9 * $signed({1'b0, sq2_q[63:20]});
      b3_q   <= 60'(sq2_q[63:28]) * 60'(s2_q[31:8]);
      t2_3_q <= t2w[PW+15:15];
      p3_q   <= p2_q;
      t1_4_q <= t1w[60:23];
      c4_q   <= 60'(b3_q[59:8]) * 60'(cal_i.p10);
      sum4_q <= (SumW'(p3_q) <<< 4) + SumW'(t2_3_q) + (SumW'(cal_i.p7) <<< 19);
      p4_q   <= p3_q;
      t3_5_q <= p4_q[PW-1] ? -$signed({1'b0, c4_q[59:21]}) : $signed({1'b0, c4_q[59:21]});
      sum5_q <= sum4_q + SumW'(t1_4_q);
      r6_q   <= sum5_q + SumW'(t3_5_q);
    end
  end

  assign res_o = '{valid: v_q[6], dz: dz_q[6], sat: sat_q[6], r: r6_q};

endmodule

// ===== design/barometric_pressure_compensation_core.sv =====
// Top level: APB calibration registers, front, divider and back pipelines, output register.
// Depends on bpc_pkg, bpc_if, bpc_poly, bpc_div and bpc_post.
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    raw_pressure, temp_fine
//  out_ch    out   valid/ready    pressure_q4, status
//  apb       in    psel/penable   paddr, pwdata, prdata (pready tied high)
//
// One request per cycle while the output is not stalled; the path runs front, divider, back, output register.
// The divider length, one quotient bit per stage, sets the latency.
// The whole pipeline holds while a result waits at the output, bubbles included.
// Reset clears valid bits and calibration registers; no clearing pass.
`timescale 1ns / 1ps
module barometric_pressure_compensation_core import bpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_in_if.sink      in_ch,
  bpc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cal_t      cal_q;
  poly_res_t poly_res;
  div_res_t  div_res;
  post_res_t post_res;
  logic      en;
  reg_idx_e  idx;

  logic            out_valid_q;
  logic [OutW-1:0] pressure_q, pressure_d;
  status_e         status_q, status_d;
  logic signed [SumW-1:0]          ow;
  logic signed [SumW-OutShift-1:0] ot;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegP1:    cal_q.p1 <= pwdata[15:0];
        RegP2:    cal_q.p2 <= pwdata[15:0];
        RegP4:    cal_q.p4 <= pwdata[15:0];
        RegP5:    cal_q.p5 <= pwdata[15:0];
        RegP8:    cal_q.p8 <= pwdata[15:0];
        RegP9:    cal_q.p9 <= pwdata[15:0];
        RegSmall: {cal_q.p10, cal_q.p7, cal_q.p6, cal_q.p3} <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegP1:    prdata = {16'd0, cal_q.p1};
      RegP2:    prdata = {{16{cal_q.p2[15]}}, cal_q.p2};
      RegP4:    prdata = {{16{cal_q.p4[15]}}, cal_q.p4};
      RegP5:    prdata = {{16{cal_q.p5[15]}}, cal_q.p5};
      RegP8:    prdata = {{16{cal_q.p8[15]}}, cal_q.p8};
      RegP9:    prdata = {{16{cal_q.p9[15]}}, cal_q.p9};
      RegSmall: prdata = {cal_q.p10, cal_q.p7, cal_q.p6, cal_q.p3};
      default:  prdata = '0;
    endcase
  end

  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;

  bpc_poly u_poly (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_ch.valid),
    .raw_pressure_i (in_ch.raw_pressure),
    .temp_fine_i    (in_ch.temp_fine),
    .cal_i          (cal_q),
    .res_o          (poly_res)
  );

  bpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (poly_res),
    .res_o  (div_res)
  );

  bpc_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (div_res),
    .cal_i  (cal_q),
    .res_o  (post_res)
  );

  // truncate toward zero, then clamp to the output range
  assign ow = post_res.r + (post_res.r[SumW-1] ? SumW'((1 << OutShift) - 1) : SumW'(0));
  assign ot = ow[SumW-1:OutShift];

  always_comb begin
    if (post_res.dz) begin
      pressure_d = '0;
      status_d   = StDivZero;
    end else if (ot[SumW-OutShift-1]) begin
      pressure_d = '0;
      status_d   = StSat;
    end else if (ot > (SumW-OutShift)'(OutMax)) begin
      pressure_d = OutMax;
      status_d   = StSat;
    end else begin
      pressure_d = ot[OutW-1:0];
      status_d   = post_res.sat ? StSat : StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= post_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pressure_q <= pressure_d;
      status_q   <= status_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.pressure_q4 = pressure_q;
  assign out_ch.status      = status_q;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == StOk || status_q == StSat || status_q == StDivZero))
    else $error("bpc: bad status code");

  a_divzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == StDivZero) |-> (pressure_q == '0))
    else $error("bpc: divisor zero with nonzero pressure");

  a_p1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cal_q.p1 == '0) |-> (status_q == StDivZero))
    else $error("bpc: zero p1 not flagged");
`endif

endmodule
